// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps

package swm_pkg;

    // Defaults for the top-level parameters
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Window size register
    localparam int              WS_BITS  = 7;
    localparam logic [WS_BITS-1:0] WS_RESET = 7'd1;

    // Register index, taken from the word address
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

    // Command broadcast from the sequencer to every cell
    typedef struct packed {
        logic age_step;   // advance all ages by one, saturating at WINDOW_MAX
        logic clear;      // with age_step: drop every entry
        logic shift;      // move every entry one cell toward the front
        logic insert;     // drop entries not above the sample, append it
    } t_cell_cmd;

    // Status of the front cell
    typedef struct packed {
        logic valid;
        logic keep;
    } t_front;

endpackage

// ===== rtl/swm_cell.sv =====
`timescale 1ns / 1ps

module swm_cell #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swm_pkg::t_cell_cmd     i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_prev_keep,
    input  logic [SAMPLE_BITS-1:0] i_nbr_value,
    input  logic [$clog2(WINDOW_MAX+1)-1:0] i_nbr_age,
    input  logic                   i_nbr_valid,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic [$clog2(WINDOW_MAX+1)-1:0] o_age,
    output logic                   o_valid,
    output logic                   o_keep
);

    localparam int AGE_W = $clog2(WINDOW_MAX + 1);

    logic [SAMPLE_BITS-1:0] r_value, n_value;
    logic [AGE_W-1:0]       r_age, n_age;
    logic                   r_valid, n_valid;
    logic                   keep;

    // Entry survives an insert while it stays strictly above the new sample
    assign keep = r_valid && ($signed(r_value) > $signed(i_sample));

    always_comb begin
        n_value = r_value;
        n_age   = r_age;
        n_valid = r_valid;
        if (i_cmd.age_step) begin
            if (r_age < AGE_W'(WINDOW_MAX)) begin
                n_age = r_age + AGE_W'(1);
            end
            if (i_cmd.clear) begin
                n_valid = 1'b0;
            end
        end else if (i_cmd.shift) begin
            n_value = i_nbr_value;
            n_age   = i_nbr_age;
            n_valid = i_nbr_valid;
        end else if (i_cmd.insert) begin
            if (!keep) begin
                if (i_prev_keep) begin
                    n_value = i_sample;
                    n_age   = '0;
                    n_valid = 1'b1;
                end else begin
                    n_valid = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_valid = r_valid;
    assign o_keep  = keep;

endmodule

// ===== rtl/swm_ctrl.sv =====
`timescale 1ns / 1ps

module swm_ctrl #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    input  logic                        i_start_req,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [SAMPLE_BITS-1:0]      o_window_max,
    input  logic [swm_pkg::WS_BITS-1:0] i_window_size,
    input  swm_pkg::t_front             i_front,
    input  logic [SAMPLE_BITS-1:0]      i_front_value,
    input  logic [$clog2(WINDOW_MAX+1)-1:0] i_front_age,
    output swm_pkg::t_cell_cmd          o_cmd,
    output logic [SAMPLE_BITS-1:0]      o_sample
);

    localparam int AGE_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (AGE_W > swm_pkg::WS_BITS) ? AGE_W : swm_pkg::WS_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state                 r_state;
    logic [AGE_W-1:0]       r_seen;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_value;

    logic [CMP_W-1:0]       ws_ext;
    logic [CMP_W-1:0]       eff_ext;
    logic [AGE_W-1:0]       eff_w;
    logic                   in_accept;
    logic                   out_free;
    logic                   expired;
    logic                   produce;
    swm_pkg::t_cell_cmd     cmd;

    // Clamp the window length into 1..WINDOW_MAX
    always_comb begin
        ws_ext = CMP_W'(i_window_size);
        if (ws_ext == '0) begin
            eff_ext = CMP_W'(1);
        end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
            eff_ext = CMP_W'(WINDOW_MAX);
        end else begin
            eff_ext = ws_ext;
        end
        eff_w = AGE_W'(eff_ext);
    end

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || i_out_ready;
    assign expired   = i_front.valid && (i_front_age >= eff_w);
    assign produce   = r_seen >= eff_w;

    always_comb begin
        cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    cmd.age_step = 1'b1;
                    cmd.clear    = i_start_req;
                end
            end
            ST_RUN: begin
                if (expired) begin
                    cmd.shift = 1'b1;
                end else if (!produce || out_free) begin
                    cmd.insert = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd.insert && produce) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_sample <= i_sample;
                        if (i_start_req) begin
                            r_seen <= AGE_W'(1);
                        end else if (r_seen < AGE_W'(WINDOW_MAX)) begin
                            r_seen <= r_seen + AGE_W'(1);
                        end
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (cmd.insert) begin
                        if (produce) begin
                            r_out_value <= i_front.keep ? i_front_value : r_sample;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_value;
    assign o_cmd        = cmd;
    assign o_sample     = r_sample;

`ifndef SYNTH
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.age_step, cmd.shift, cmd.insert}))
        else $error("more than one cell command in a cycle");

    a_insert_after_purge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.insert |-> !expired)
        else $error("insert while the front entry is out of the window");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.insert && produce) |=> r_out_valid)
        else $error("result lost at insert");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= AGE_W'(WINDOW_MAX))
        else $error("sample count beyond window capacity");

    a_clear_with_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> (cmd.age_step && in_accept))
        else $error("clear outside an accepted transaction");
`endif

endmodule

// ===== rtl/sliding_window_max.sv =====
`timescale 1ns / 1ps

// Running maximum of the last window_size signed samples. Each input transaction
// carries one sample and an optional start flag that empties the window first;
// once window_size samples have arrived since the start, each sample yields one
// output transaction with the window maximum. window_size (register 0, bits 6:0)
// acts as 1 when written 0 and as WINDOW_MAX above it; write it only while the
// block is idle, and a new length applies from the next sample. Each sample is
// accepted with an age step; then the chain of cells moves its entries one
// position per cycle to drop each kept entry that has aged out of the window at
// the front (normally none or one; more only right after the window is
// shortened); then the sample is inserted, which waits while the previous result
// still waits to be taken when the sample is ready to produce its own.
// A finished result waits in an output register while the next sample is taken.
// No clearing pass follows reset.

module sliding_window_max #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample stream
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_start_req,
    // window maximum stream
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_window_max,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AGE_W = $clog2(WINDOW_MAX + 1);

    logic [swm_pkg::WS_BITS-1:0] r_window_size;
    logic                        reg_sel;

    swm_pkg::t_cell_cmd          cmd;
    swm_pkg::t_front             front;
    logic [SAMPLE_BITS-1:0]      sample;

    // Cell outputs; entry 0 is the front (oldest and largest kept sample)
    logic [SAMPLE_BITS-1:0]      cell_value [WINDOW_MAX];
    logic [AGE_W-1:0]            cell_age   [WINDOW_MAX];
    logic                        cell_valid [WINDOW_MAX];
    logic                        cell_keep  [WINDOW_MAX];

    // Register access: a write lands on the access phase, reads are combinational
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == swm_pkg::REG_WINDOW_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::WS_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_window_size <= pwdata[swm_pkg::WS_BITS-1:0];
        end
    end

    assign prdata = reg_sel ? 32'(r_window_size) : 32'd0;

    // Sequencer: ages all entries on accept, drops expired front entries one
    // cycle at a time, then inserts the sample and, once the window is full, loads the result
    swm_ctrl #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .i_start_req   (i_start_req),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_window_max  (o_window_max),
        .i_window_size (r_window_size),
        .i_front       (front),
        .i_front_value (cell_value[0]),
        .i_front_age   (cell_age[0]),
        .o_cmd         (cmd),
        .o_sample      (sample)
    );

    assign front.valid = cell_valid[0];
    assign front.keep  = cell_keep[0];

    // Chain of cells: each takes its back neighbor on a shift, and the first
    // cell that does not survive an insert takes the new sample
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic                   prev_keep;
        logic [SAMPLE_BITS-1:0] nbr_value;
        logic [AGE_W-1:0]       nbr_age;
        logic                   nbr_valid;

        if (g == 0) begin : g_head
            assign prev_keep = 1'b1;
        end else begin : g_body
            assign prev_keep = cell_keep[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_tail
            // Nothing behind the last cell: a shift empties it
            assign nbr_value = '0;
            assign nbr_age   = '0;
            assign nbr_valid = 1'b0;
        end else begin : g_link
            assign nbr_value = cell_value[g+1];
            assign nbr_age   = cell_age[g+1];
            assign nbr_valid = cell_valid[g+1];
        end

        swm_cell #(
            .WINDOW_MAX  (WINDOW_MAX),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_sample    (sample),
            .i_prev_keep (prev_keep),
            .i_nbr_value (nbr_value),
            .i_nbr_age   (nbr_age),
            .i_nbr_valid (nbr_valid),
            .o_value     (cell_value[g]),
            .o_age       (cell_age[g]),
            .o_valid     (cell_valid[g]),
            .o_keep      (cell_keep[g])
        );
    end

endmodule
